// ----- rtl/mfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types and constants of the motor feedback frame parser.
// ----------------------------------------------------------------------------
package mfp_pkg;

    localparam logic [7:0]  SYNC_FIRST   = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND  = 8'h55;
    localparam logic [7:0]  MIN_LENGTH   = 8'd15;
    localparam logic [15:0] FORCE_SPLIT  = 16'hC350;
    localparam logic [15:0] FORCE_FULL   = 16'hFFFF;

    // x / 100 == (x * DIV100_MULT) >> DIV100_SHIFT for every 16-bit x
    localparam int          DIV100_SHIFT = 24;
    localparam logic [17:0] DIV100_MULT  = 18'd167773;

    localparam int          CAP_DEPTH    = 16;
    localparam int          CAP_IDX_W    = $clog2(CAP_DEPTH);

    // configuration register indexes
    localparam logic [7:0]  CFG_MAX_MOTOR_INDEX = 8'd0;
    localparam logic [7:0]  CFG_POSITION_LIMIT  = 8'd1;

    localparam logic [7:0]  MAX_MOTOR_INDEX_RST = 8'd6;
    localparam logic [15:0] POSITION_LIMIT_RST  = 16'd2000;

    typedef logic [CAP_DEPTH-1:0][7:0] cap_array_t;

    typedef struct packed {
        logic [7:0]  max_motor_index;
        logic [15:0] position_limit;
    } cfg_t;

    // end-of-frame event from the parser to the record builder
    typedef struct packed {
        logic       done;
        logic       short_frame;
        cap_array_t frame_bytes;
    } frame_end_t;

endpackage
`default_nettype wire

// ----- rtl/mfp_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfp_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module mfp_in_stage
    import mfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       advance,
    output logic            s1_valid,
    output logic [7:0]      s1_byte
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;

    // only blocks when a byte is parked here and the pipe cannot move
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_byte  = s1_byte_reg;

endmodule
`default_nettype wire

// ----- rtl/mfp_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfp_parser
// Sync hunt, length capture and body byte capture for feedback frames.
// ----------------------------------------------------------------------------
module mfp_parser
    import mfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s1_valid,
    input  wire logic [7:0] s1_byte,
    input  wire logic       advance,
    output frame_end_t      frame_end
);

    typedef enum logic [1:0] {
        HUNT,
        SYNC2,
        LENGTH,
        BODY
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] len_reg, len_next;
    cap_array_t cap_reg, cap_next;
    logic       fire;
    logic       done;

    assign fire = s1_valid && advance;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        cap_next   = cap_reg;
        done       = 1'b0;
        if (fire)
        begin
            case (phase_reg)
                HUNT:
                begin
                    if (s1_byte == SYNC_FIRST)
                        phase_next = SYNC2;
                end
                SYNC2:
                begin
                    // a repeated AA keeps us waiting for 55
                    if (s1_byte == SYNC_SECOND)
                        phase_next = LENGTH;
                    else if (s1_byte != SYNC_FIRST)
                        phase_next = HUNT;
                end
                LENGTH:
                begin
                    len_next   = s1_byte;
                    count_next = 8'd0;
                    phase_next = BODY;
                end
                BODY:
                begin
                    if (count_reg[7:CAP_IDX_W] == '0)
                        cap_next[count_reg[CAP_IDX_W-1:0]] = s1_byte;
                    if (count_reg >= len_reg)
                    begin
                        done       = 1'b1;
                        phase_next = HUNT;
                        count_next = 8'd0;
                    end
                    else
                    begin
                        count_next = count_reg + 8'd1;
                    end
                end
                default:
                begin
                    phase_next = HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= HUNT;
            count_reg <= 8'd0;
            len_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_reg <= cap_next;
    end

    // last body byte is forwarded so a minimum-length frame sees its fault byte
    assign frame_end.done        = done;
    assign frame_end.short_frame = (len_reg < MIN_LENGTH);
    assign frame_end.frame_bytes = cap_next;

endmodule
`default_nettype wire

// ----- rtl/mfp_record_out.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfp_record_out
// Frame checks, force decode and the result register.
// ----------------------------------------------------------------------------
module mfp_record_out
    import mfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire frame_end_t  frame_end,
    input  wire cfg_t        cfg,
    output logic             out_valid,
    output logic             record_ok,
    output logic [7:0]       motor_id,
    output logic [15:0]      actual_pos,
    output logic [15:0]      commanded_pos,
    output logic [15:0]      current_draw,
    output logic signed [9:0] force_value,
    output logic [15:0]      initial_force,
    output logic [7:0]       temperature,
    output logic [7:0]       fault_status
);

    localparam int PROD_W = 16 + $bits(DIV100_MULT);

    logic [7:0]        idx;
    logic [15:0]       cur_pos;
    logic [15:0]       tgt_pos;
    logic [15:0]       draw;
    logic [15:0]       force_word;
    logic [15:0]       init_word;
    logic              force_neg;
    logic [15:0]       div_opnd;
    logic [PROD_W-1:0] div_prod;
    logic [9:0]        quot;
    logic [9:0]        force_dec;
    logic              ok;

    logic              valid_reg;
    logic              ok_reg;
    logic [7:0]        idx_reg;
    logic [15:0]       cur_reg;
    logic [15:0]       tgt_reg;
    logic [15:0]       draw_reg;
    logic [9:0]        force_reg;
    logic [15:0]       init_reg;
    logic [7:0]        temp_reg;
    logic [7:0]        fault_reg;

    assign idx        = frame_end.frame_bytes[0];
    assign tgt_pos    = {frame_end.frame_bytes[5],  frame_end.frame_bytes[4]};
    assign cur_pos    = {frame_end.frame_bytes[7],  frame_end.frame_bytes[6]};
    assign draw       = {frame_end.frame_bytes[9],  frame_end.frame_bytes[8]};
    assign force_word = {frame_end.frame_bytes[11], frame_end.frame_bytes[10]};
    assign init_word  = {frame_end.frame_bytes[13], frame_end.frame_bytes[12]};

    assign ok = !frame_end.short_frame
             && (idx != 8'd0)
             && (idx <= cfg.max_motor_index)
             && (cur_pos <= cfg.position_limit)
             && (tgt_pos <= cfg.position_limit);

    // raw above the split encodes a negative force, magnitude (FFFF - raw) / 100
    assign force_neg = (force_word > FORCE_SPLIT);
    assign div_opnd  = force_neg ? (FORCE_FULL - force_word) : force_word;
    assign div_prod  = PROD_W'(div_opnd) * PROD_W'(DIV100_MULT);
    assign quot      = div_prod[DIV100_SHIFT +: 10];
    assign force_dec = force_neg ? (10'd0 - quot) : quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= frame_end.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && frame_end.done)
        begin
            ok_reg    <= ok;
            idx_reg   <= ok ? idx : 8'd0;
            cur_reg   <= ok ? cur_pos : 16'd0;
            tgt_reg   <= ok ? tgt_pos : 16'd0;
            draw_reg  <= ok ? draw : 16'd0;
            force_reg <= ok ? force_dec : 10'd0;
            init_reg  <= ok ? init_word : 16'd0;
            temp_reg  <= ok ? frame_end.frame_bytes[14] : 8'd0;
            fault_reg <= ok ? frame_end.frame_bytes[15] : 8'd0;
        end
    end

    assign out_valid     = valid_reg;
    assign record_ok     = ok_reg;
    assign motor_id      = idx_reg;
    assign actual_pos    = cur_reg;
    assign commanded_pos = tgt_reg;
    assign current_draw  = draw_reg;
    assign force_value   = $signed(force_reg);
    assign initial_force = init_reg;
    assign temperature   = temp_reg;
    assign fault_status  = fault_reg;

endmodule
`default_nettype wire

// ----- rtl/motor_feedback_frame_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motor_feedback_frame_parser
// Parses motor feedback frames (AA 55, length L, L+1 body bytes) from a byte
// stream and emits one record per frame.
//
// Input channel: in_valid / in_stall with rx_byte; one byte per transaction.
// Output channel: out_valid / out_stall with the record fields; one record per
// frame, issued on the frame's last byte. Rejected frames give record_ok = 0
// with all other fields zero.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// 0 = max_motor_index, 1 = position_limit; other indexes are ignored.
// Write config only while no frame is in flight.
// Throughput: one byte per cycle while no record is stalled. A byte passes the
// input register, then the parser plus record register, which holds the record
// of the frame's last byte (the force divide by 100 is a single constant multiply).
// Reset: parser hunts for sync, config returns to 6 and 2000, no record held.
// Stall: a waiting record holds the pipe; if the input register is empty, one
// more byte is still taken into it before in_stall rises.
// ----------------------------------------------------------------------------
module motor_feedback_frame_parser
    import mfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             record_ok,
    output logic [7:0]       motor_id,
    output logic [15:0]      actual_pos,
    output logic [15:0]      commanded_pos,
    output logic [15:0]      current_draw,
    output logic signed [9:0] force_value,
    output logic [15:0]      initial_force,
    output logic [7:0]       temperature,
    output logic [7:0]       fault_status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t       cfg_reg;
    logic       advance;
    logic       s1_valid;
    logic [7:0] s1_byte;
    frame_end_t frame_end;

    assign cfg_ready = 1'b1;
    assign advance   = !(out_valid && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_motor_index <= MAX_MOTOR_INDEX_RST;
            cfg_reg.position_limit  <= POSITION_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MAX_MOTOR_INDEX)
                cfg_reg.max_motor_index <= cfg_data[7:0];
            else if (cfg_index == CFG_POSITION_LIMIT)
                cfg_reg.position_limit <= cfg_data;
        end
    end

    mfp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_byte  (s1_byte)
    );

    mfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_byte   (s1_byte),
        .advance   (advance),
        .frame_end (frame_end)
    );

    mfp_record_out u_record_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .frame_end     (frame_end),
        .cfg           (cfg_reg),
        .out_valid     (out_valid),
        .record_ok     (record_ok),
        .motor_id      (motor_id),
        .actual_pos    (actual_pos),
        .commanded_pos (commanded_pos),
        .current_draw  (current_draw),
        .force_value   (force_value),
        .initial_force (initial_force),
        .temperature   (temperature),
        .fault_status  (fault_status)
    );

    // input only backs up behind a stalled record
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a stalled record");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !record_ok) |-> (motor_id == 8'd0 && actual_pos == 16'd0
            && commanded_pos == 16'd0 && current_draw == 16'd0 && force_value == 10'sd0
            && initial_force == 16'd0 && temperature == 8'd0 && fault_status == 8'd0))
        else $error("rejected record carries nonzero fields");

    a_accept_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && record_ok) |-> (motor_id != 8'd0
            && motor_id <= cfg_reg.max_motor_index
            && actual_pos <= cfg_reg.position_limit
            && commanded_pos <= cfg_reg.position_limit))
        else $error("accepted record outside configured limits");

    a_force_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && record_ok) |-> (force_value >= -10'sd155 && force_value <= 10'sd500))
        else $error("decoded force out of range");

endmodule
`default_nettype wire

// ----- tb/sv/motor_feedback_frame_parser_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_frame_parser_test
// Feeds byte streams of sync pairs, length bytes and frame bodies into the
// parser. A scoreboard tracks the framing and predicts each record, including
// reject rules and force decode. Records are compared in order. Both sides
// idle and stall at random, and register settings change between drained
// phases.
// ----------------------------------------------------------------------------
module motor_feedback_frame_parser_test;
    import mfp_pkg::*;

    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int FORCE_SCALE   = 100;
    localparam int TIMEOUT_NS    = 4_000_000;

    typedef enum logic [1:0] {HUNT_AA, WAIT_55, TAKE_LEN, FRAME_BODY} parse_phase_t;

    typedef struct packed {
        logic              ok;
        logic [7:0]        motor;
        logic [15:0]       cur_pos;
        logic [15:0]       tgt_pos;
        logic [15:0]       draw;
        logic signed [9:0] force_val;
        logic [15:0]       start_force;
        logic [7:0]        temp;
        logic [7:0]        fault;
    } frame_record_t;

    class frame_record_scoreboard;
        parse_phase_t  phase;
        int            body_count;
        logic [7:0]    frame_len;
        logic [7:0]    captured [CAP_DEPTH];
        logic [7:0]    max_idx;
        logic [15:0]   pos_limit;
        frame_record_t pending_records [$];
        int            records_ok;
        int            records_rejected;
        int            mismatches;

        function new();
            phase = HUNT_AA;
            body_count = 0;
            frame_len = '0;
            foreach (captured[i]) captured[i] = '0;
            max_idx = MAX_MOTOR_INDEX_RST;
            pos_limit = POSITION_LIMIT_RST;
            records_ok = 0;
            records_rejected = 0;
            mismatches = 0;
        endfunction

        function logic [15:0] word_at(int lo);
            return {captured[lo + 1], captured[lo]};
        endfunction

        function void note_register(logic [7:0] idx, logic [15:0] value);
            case (idx)
                CFG_MAX_MOTOR_INDEX: max_idx = value[7:0];
                CFG_POSITION_LIMIT:  pos_limit = value;
                default: ;
            endcase
        endfunction

        // advance the framing by one accepted byte; queue a record at frame end
        function void take_byte(logic [7:0] b);
            frame_record_t rec;
            logic [15:0]   cur;
            logic [15:0]   tgt;
            logic [15:0]   raw;
            case (phase)
                HUNT_AA:
                    if (b == SYNC_FIRST)
                        phase = WAIT_55;
                WAIT_55:
                    if (b == SYNC_SECOND)
                        phase = TAKE_LEN;
                    else if (b != SYNC_FIRST)
                        phase = HUNT_AA;
                TAKE_LEN:
                begin
                    frame_len = b;
                    body_count = 0;
                    phase = FRAME_BODY;
                end
                default:
                begin
                    if (body_count < CAP_DEPTH)
                        captured[body_count] = b;
                    if (body_count >= frame_len)
                    begin
                        rec = '0;
                        cur = word_at(6);
                        tgt = word_at(4);
                        if (frame_len >= MIN_LENGTH && captured[0] != 8'd0 &&
                            captured[0] <= max_idx && cur <= pos_limit &&
                            tgt <= pos_limit)
                        begin
                            raw = word_at(10);
                            rec.ok = 1'b1;
                            rec.motor = captured[0];
                            rec.cur_pos = cur;
                            rec.tgt_pos = tgt;
                            rec.draw = word_at(8);
                            // negative side truncates toward zero
                            if (raw > FORCE_SPLIT)
                                rec.force_val = -10'((FORCE_FULL - raw) / FORCE_SCALE);
                            else
                                rec.force_val = 10'(raw / FORCE_SCALE);
                            rec.start_force = word_at(12);
                            rec.temp = captured[14];
                            rec.fault = captured[15];
                        end
                        pending_records = {pending_records, rec};
                        phase = HUNT_AA;
                        body_count = 0;
                    end
                    else
                        body_count++;
                end
            endcase
        endfunction

        function string describe(frame_record_t r);
            return {$sformatf("ok=%0d idx=%0d cur=%0d tgt=%0d draw=%0d",
                              r.ok, r.motor, r.cur_pos, r.tgt_pos, r.draw),
                    $sformatf(" force=%0d init=%0d temp=%0d fault=%0d",
                              r.force_val, r.start_force, r.temp, r.fault)};
        endfunction

        function void compare_record(frame_record_t got);
            frame_record_t want;
            if (pending_records.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected record: %s", describe(got));
                return;
            end
            want = pending_records.pop_front();
            if (want.ok)
                records_ok++;
            else
                records_rejected++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("record %0d wrong\n  expected %s\n  actual   %s",
                             records_ok + records_rejected, describe(want), describe(got));
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        rx_byte = 8'h00;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              record_ok;
    logic [7:0]        motor_id;
    logic [15:0]       actual_pos;
    logic [15:0]       commanded_pos;
    logic [15:0]       current_draw;
    logic signed [9:0] force_value;
    logic [15:0]       initial_force;
    logic [7:0]        temperature;
    logic [7:0]        fault_status;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_index = 8'h00;
    logic [15:0]       cfg_data = 16'h0000;

    frame_record_scoreboard board = new();
    frame_record_t          observed;
    int                     sent_bytes = 0;
    int                     frame_bytes = 0;
    int                     frames_sent = 0;
    int                     settings_used = 0;

    motor_feedback_frame_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .record_ok     (record_ok),
        .motor_id      (motor_id),
        .actual_pos    (actual_pos),
        .commanded_pos (commanded_pos),
        .current_draw  (current_draw),
        .force_value   (force_value),
        .initial_force (initial_force),
        .temperature   (temperature),
        .fault_status  (fault_status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // one byte per transaction; burst suppresses the idle gap
    task automatic push_byte(input logic [7:0] b, input bit burst);
        int gap;
        int r;
        gap = 0;
        r = $urandom_range(0, 99);
        if (!burst && r >= 60)
            gap = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 50);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (in_stall);
        board.take_byte(b);
        sent_bytes++;
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] head [CAP_DEPTH]);
        bit burst;
        burst = ($urandom_range(0, 99) < 30);
        push_byte(SYNC_FIRST, burst);
        push_byte(SYNC_SECOND, burst);
        push_byte(len, burst);
        for (int i = 0; i <= len; i++)
            push_byte((i < CAP_DEPTH) ? head[i] : 8'($urandom), burst);
        frame_bytes += len + 4;
        frames_sent++;
    endtask

    task automatic send_fields(input logic [7:0] len, input logic [7:0] idx,
                               input logic [15:0] cur, input logic [15:0] tgt,
                               input logic [15:0] draw, input logic [15:0] raw,
                               input logic [15:0] init, input logic [7:0] temp,
                               input logic [7:0] fault);
        logic [7:0] head [CAP_DEPTH];
        foreach (head[i]) head[i] = 8'($urandom);
        head[0] = idx;
        {head[5], head[4]} = tgt;
        {head[7], head[6]} = cur;
        {head[9], head[8]} = draw;
        {head[11], head[10]} = raw;
        {head[13], head[12]} = init;
        head[14] = temp;
        head[15] = fault;
        send_frame(len, head);
    endtask

    function automatic logic [15:0] pick_position();
        int lim;
        int r;
        lim = board.pos_limit;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 16'($urandom_range(0, lim));
        if (r < 75)
            return 16'(lim);
        if (r < 85)
            return 16'(lim + 1);
        return 16'($urandom);
    endfunction

    // close any open frame, let every record come out, then settle
    task automatic drain();
        while (board.phase != HUNT_AA)
            push_byte(8'h00, 1'b1);
        in_valid <= 1'b0;
        while (board.pending_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input logic [7:0] max_idx, input logic [15:0] lim);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MAX_MOTOR_INDEX;
        cfg_data <= {8'h00, max_idx};
        do @(posedge clk); while (!cfg_ready);
        board.note_register(CFG_MAX_MOTOR_INDEX, {8'h00, max_idx});
        cfg_index <= CFG_POSITION_LIMIT;
        cfg_data <= lim;
        do @(posedge clk); while (!cfg_ready);
        board.note_register(CFG_POSITION_LIMIT, lim);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic random_phase(input int quota);
        logic [7:0]  head [CAP_DEPTH];
        logic [15:0] corners [8];
        logic [7:0]  len;
        int          start;
        int          r;
        int          top;
        corners = '{16'h0000, 16'h0063, 16'h0064, 16'hC34F, FORCE_SPLIT, 16'hC351,
                    16'hFF9B, FORCE_FULL};
        start = frame_bytes;
        while (frame_bytes - start < quota)
        begin
            // noise and broken sync between frames
            r = $urandom_range(0, 99);
            if (r < 8)
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0);
            else if (r < 14)
            begin
                push_byte(SYNC_FIRST, 1'b0);
                push_byte(($urandom_range(0, 1) == 0) ? 8'h12 : 8'($urandom_range(0, 84)),
                          1'b0);
            end
            else if (r < 20)
                push_byte(SYNC_FIRST, 1'b0);

            foreach (head[i]) head[i] = 8'($urandom);
            top = board.max_idx;
            r = $urandom_range(0, 99);
            if (r < 70)
                head[0] = 8'($urandom_range(1, (top > 0) ? top : 1));
            else if (r < 80)
                head[0] = 8'd0;
            else if (r < 90)
                head[0] = 8'(top + 1);
            {head[7], head[6]} = pick_position();
            {head[5], head[4]} = pick_position();
            if ($urandom_range(0, 99) < 30)
                {head[11], head[10]} = corners[$urandom_range(0, 7)];

            r = $urandom_range(0, 99);
            if (r < 10)
                len = 8'($urandom_range(0, 14));
            else if (r < 13)
                len = 8'($urandom_range(21, 255));
            else if (r < 35)
                len = MIN_LENGTH;
            else
                len = 8'($urandom_range(16, 20));
            send_frame(len, head);
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            observed.ok = record_ok;
            observed.motor = motor_id;
            observed.cur_pos = actual_pos;
            observed.tgt_pos = commanded_pos;
            observed.draw = current_draw;
            observed.force_val = force_value;
            observed.start_force = initial_force;
            observed.temp = temperature;
            observed.fault = fault_status;
            board.compare_record(observed);
        end
    end

    // receiver side: random stalls, plus two long holds while bytes keep coming
    initial
    begin
        int r;
        int holds;
        holds = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (holds < 2 && sent_bytes >= 200 + 600 * holds)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                holds++;
            end
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
            else if (r < 93)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(8, 40)) @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames under reset settings (max index 6, limit 2000)
        send_fields(MIN_LENGTH, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_fields(MIN_LENGTH, 8'd6, 16'd2000, 16'd2000, 16'hFFFF, FORCE_SPLIT,
                    16'hFFFF, 8'hFF, 8'hFF);
        send_fields(8'd16, 8'd3, 16'd1000, 16'd17, 16'd1234, 16'hC351, 16'd42,
                    8'd25, 8'd0);
        send_fields(8'd17, 8'd2, 16'd5, 16'd1999, 16'd7, FORCE_FULL, 16'd9, 8'd30, 8'd3);
        send_fields(8'd20, 8'd4, 16'd77, 16'd88, 16'd99, 16'hFF9B, 16'd1, 8'd2, 8'd4);
        send_fields(MIN_LENGTH, 8'd5, 16'd10, 16'd10, 16'd1, 16'd99, 16'd100,
                    8'h80, 8'h01);
        // reject rules: bad index, positions over limit
        send_fields(MIN_LENGTH, 8'd0, 16'd1, 16'd1, 16'd1, 16'd100, 16'd1, 8'd1, 8'd1);
        send_fields(MIN_LENGTH, 8'd7, 16'd1, 16'd1, 16'd1, 16'd100, 16'd1, 8'd1, 8'd1);
        send_fields(MIN_LENGTH, 8'd255, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 8'd1, 8'd1);
        send_fields(MIN_LENGTH, 8'd1, 16'd2001, 16'd0, 16'd1, 16'd1, 16'd1, 8'd1, 8'd1);
        send_fields(MIN_LENGTH, 8'd1, 16'd0, 16'd2001, 16'd1, 16'd1, 16'd1, 8'd1, 8'd1);
        send_fields(MIN_LENGTH, 8'd2, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1, 8'd1, 8'd1);
        // short frames are consumed but rejected
        send_fields(8'd0, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_fields(8'd14, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        // broken sync, then a repeated first sync byte before a good pair
        push_byte(SYNC_FIRST, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(SYNC_FIRST, 1'b0);
        send_fields(MIN_LENGTH, 8'd3, 16'd300, 16'd400, 16'd5, 16'd5000, 16'd6,
                    8'd7, 8'd8);
        send_fields(8'd255, 8'd6, 16'd1, 16'd2, 16'd3, 16'hE000, 16'd5, 8'd6, 8'd7);
        drain();

        random_phase(150);
        apply_config(8'd255, 16'hFFFF);
        random_phase(120);
        apply_config(8'd1, 16'h0000);
        random_phase(80);
        apply_config(8'd0, 16'd2000);   // index limit of zero rejects everything
        random_phase(40);
        repeat (2)
        begin
            apply_config(8'($urandom_range(1, 255)), 16'($urandom));
            random_phase(100);
        end

        board.mismatches += board.pending_records.size();
        $display("sent %0d bytes in %0d frames; %0d records accepted, %0d rejected",
                 sent_bytes, frames_sent, board.records_ok, board.records_rejected);
        $display("covered %0d register settings beyond reset, long output holds and drains",
                 settings_used);
        if (board.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
